/* design/rrts_pkg.sv */
// Shared types, codes and constants for the round-robin task scheduler.
package rrts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int RATE_W    = 17;
  localparam int TICK_W    = 32;
  localparam int STACK_W   = 16;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int SST_W     = 2;

  localparam logic [RATE_W-1:0]  RATE_RESET = 17'd1000;
  localparam logic [STACK_W-1:0] MIN_STACK  = 16'd64;
  localparam logic [TICK_W-1:0]  ROUND_UP   = 32'd999;
  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam logic [28:0]        RECIP_1000  = 29'd274877907;
  localparam int                 RECIP_SHIFT = 38;

  localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_YIELD  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELAY  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_EXIT   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_STACK     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_ALLOW = 2'd3;

  localparam logic [SST_W-1:0] SLOT_READY    = 2'd0;
  localparam logic [SST_W-1:0] SLOT_SLEEPING = 2'd1;
  localparam logic [SST_W-1:0] SLOT_DONE     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_SLEEP,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

/* design/rrts_ram.sv */
// Generic simple dual-port RAM with registered read.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/round_robin_task_scheduler_top.sv */
// Top level of the round-robin task scheduler: control FSM, slot scan and delay math.
// Sequence: each request passes EXEC, then DONE; a tick and an accepted start,
//   yield or exit scan the slot table before DONE (one slot-table read per cycle); a
//   running delay does MUL, DIV (two multiplies) and SLEEP (sleep write-back) first.
// Throughput: one request at a time; a new request is taken while the last result waits.
// Reset (rst_n low, synchronous): empty table, idle task current, not started, tick 0,
//   tick rate 1000. Slot memories hold no reset state and need no clearing pass.
module round_robin_task_scheduler_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rrts_pkg::RATE_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rrts_pkg::REQ_W-1:0]    in_req_type,
  input  logic [rrts_pkg::STACK_W-1:0]  in_stack_size_bytes,
  input  logic [rrts_pkg::TICK_W-1:0]   in_delay_millis,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrts_pkg::STAT_W-1:0]   out_status,
  output logic [rrts_pkg::IDX_W-1:0]    out_new_task_id,
  output logic [rrts_pkg::IDX_W-1:0]    out_running_task,
  output logic                          out_idle_running,
  output logic [rrts_pkg::TICK_W-1:0]   out_tick_now
);
  import rrts_pkg::*;

  state_t state_r, state_nxt;

  // scheduler state
  logic [RATE_W-1:0]  rate_r;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic               on_idle_r, on_idle_nxt;
  logic               started_r, started_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;

  // latched request
  logic [REQ_W-1:0]   req_r;
  logic [STACK_W-1:0] stack_r;
  logic [TICK_W-1:0]  ms_r;

  // result under construction
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic [IDX_W-1:0]   new_id_r, new_id_nxt;

  // delay arithmetic
  logic [TICK_W-1:0]  prod_r, prod_nxt;
  logic [TICK_W-1:0]  quot_r, quot_nxt;
  logic [48:0]        rate_prod;
  logic [TICK_W-1:0]  rounded;
  logic [63:0]        recip_prod;
  logic [TICK_W-1:0]  ticks;

  // scan pipeline: issue one read per cycle, check the one issued last cycle
  logic               scan_tick_r, scan_tick_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   scan_left_r, scan_left_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               found;
  logic               scan_end;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_stat_r;
  logic [IDX_W-1:0]   out_new_id_r, out_run_r;
  logic               out_idle_r;
  logic [TICK_W-1:0]  out_tick_r;
  logic               out_load;

  // memory ports
  logic               sst_we, wake_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [SST_W-1:0]   sst_wdata, sst_rdata;
  logic [TICK_W-1:0]  wake_wdata, wake_rdata;

  logic               running;
  logic               accept;

  assign running  = started_r && !on_idle_r;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign rate_prod  = ms_r * rate_r;
  assign rounded    = prod_r + ROUND_UP;
  assign recip_prod = {32'd0, rounded} * {35'd0, RECIP_1000};
  assign ticks      = (quot_r == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : quot_r;

  assign found    = chk_vld_r && !scan_tick_r && (sst_rdata == SLOT_READY);
  assign scan_end = found || (!chk_vld_r && (scan_left_r == '0));

  rrts_ram #(.WIDTH(SST_W), .DEPTH(MAX_TASKS)) u_sst_ram (
    .clk   (clk),
    .we    (sst_we),
    .waddr (mem_waddr),
    .wdata (sst_wdata),
    .raddr (mem_raddr),
    .rdata (sst_rdata)
  );

  rrts_ram #(.WIDTH(TICK_W), .DEPTH(MAX_TASKS)) u_wake_ram (
    .clk   (clk),
    .we    (wake_we),
    .waddr (mem_waddr),
    .wdata (wake_wdata),
    .raddr (mem_raddr),
    .rdata (wake_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_r)
          REQ_START: state_nxt = started_r ? S_DONE : S_SCAN;
          REQ_TICK:  state_nxt = S_SCAN;
          REQ_YIELD,
          REQ_EXIT:  state_nxt = running ? S_SCAN : S_DONE;
          REQ_DELAY: state_nxt = running ? S_MUL : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_MUL:   state_nxt = S_DIV;
      S_DIV:   state_nxt = S_SLEEP;
      S_SLEEP: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    used_nxt      = used_r;
    cur_nxt       = cur_r;
    on_idle_nxt   = on_idle_r;
    started_nxt   = started_r;
    tick_nxt      = tick_r;
    stat_nxt      = stat_r;
    new_id_nxt    = new_id_r;
    prod_nxt      = prod_r;
    quot_nxt      = quot_r;
    scan_tick_nxt = scan_tick_r;
    scan_idx_nxt  = scan_idx_r;
    scan_left_nxt = scan_left_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    out_valid_nxt = out_valid_r;
    sst_we        = 1'b0;
    wake_we       = 1'b0;
    mem_waddr     = cur_r;
    mem_raddr     = scan_idx_r;
    sst_wdata     = SLOT_READY;
    wake_wdata    = tick_r + ticks;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_EXEC: begin
        stat_nxt      = STAT_OK;
        new_id_nxt    = '0;
        scan_tick_nxt = 1'b0;
        scan_left_nxt = used_r;
        // round-robin order starts just after the current slot
        scan_idx_nxt  = ({1'b0, cur_r} + 1'b1 == used_r) ? '0 : cur_r + 1'b1;
        unique case (req_r)
          REQ_CREATE: begin
            if (stack_r < MIN_STACK) begin
              stat_nxt = STAT_STACK;
            end else if (used_r >= CNT_W'(MAX_TASKS)) begin
              stat_nxt = STAT_FULL;
            end else begin
              new_id_nxt = used_r[IDX_W-1:0];
              sst_we     = 1'b1;
              mem_waddr  = used_r[IDX_W-1:0];
              sst_wdata  = SLOT_READY;
              used_nxt   = used_r + 1'b1;
            end
          end
          REQ_START: begin
            if (started_r) begin
              stat_nxt = STAT_NOT_ALLOW;
            end else begin
              started_nxt  = 1'b1;
              scan_idx_nxt = '0;
            end
          end
          REQ_TICK: begin
            tick_nxt      = tick_r + 1'b1;
            scan_tick_nxt = 1'b1;
            scan_idx_nxt  = '0;
          end
          REQ_YIELD: begin
            if (!running) begin
              stat_nxt = STAT_NOT_ALLOW;
            end
          end
          REQ_DELAY: begin
            if (!running) begin
              stat_nxt = STAT_NOT_ALLOW;
            end
          end
          REQ_EXIT: begin
            if (!running) begin
              stat_nxt = STAT_NOT_ALLOW;
            end else begin
              sst_we    = 1'b1;
              sst_wdata = SLOT_DONE;
            end
          end
          default: stat_nxt = STAT_NOT_ALLOW;
        endcase
      end
      S_MUL: begin
        prod_nxt = rate_prod[TICK_W-1:0];
      end
      S_DIV: begin
        quot_nxt = {6'd0, recip_prod[63:RECIP_SHIFT]};
      end
      S_SLEEP: begin
        // park the current task; the scan starts after this write lands
        sst_we    = 1'b1;
        wake_we   = 1'b1;
        sst_wdata = SLOT_SLEEPING;
      end
      S_SCAN: begin
        if (scan_left_r != '0) begin
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = scan_idx_r;
          scan_left_nxt = scan_left_r - 1'b1;
          scan_idx_nxt  = ({1'b0, scan_idx_r} + 1'b1 == used_r) ? '0 : scan_idx_r + 1'b1;
        end
        if (scan_tick_r && chk_vld_r && (sst_rdata == SLOT_SLEEPING) &&
            (tick_r >= wake_rdata)) begin
          sst_we    = 1'b1;
          mem_waddr = chk_idx_r;
          sst_wdata = SLOT_READY;
        end
        if (scan_end && !scan_tick_r) begin
          if (found) begin
            on_idle_nxt = 1'b0;
            cur_nxt     = chk_idx_r;
          end else begin
            on_idle_nxt = 1'b1;
            cur_nxt     = '0;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= RATE_RESET;
      used_r      <= '0;
      cur_r       <= '0;
      on_idle_r   <= 1'b1;
      started_r   <= 1'b0;
      tick_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cur_r       <= cur_nxt;
      on_idle_r   <= on_idle_nxt;
      started_r   <= started_nxt;
      tick_r      <= tick_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      stack_r <= in_stack_size_bytes;
      ms_r    <= in_delay_millis;
    end
    stat_r      <= stat_nxt;
    new_id_r    <= new_id_nxt;
    prod_r      <= prod_nxt;
    quot_r      <= quot_nxt;
    scan_tick_r <= scan_tick_nxt;
    scan_idx_r  <= scan_idx_nxt;
    scan_left_r <= scan_left_nxt;
    chk_idx_r   <= chk_idx_nxt;
    if (out_load) begin
      out_stat_r   <= stat_r;
      out_new_id_r <= new_id_r;
      out_run_r    <= on_idle_r ? '0 : cur_r;
      out_idle_r   <= on_idle_r;
      out_tick_r   <= tick_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_stat_r;
  assign out_new_task_id  = out_new_id_r;
  assign out_running_task = out_run_r;
  assign out_idle_running = out_idle_r;
  assign out_tick_now     = out_tick_r;

endmodule

/* design/rrts_checker.sv */
// Port-level assertions for the round-robin task scheduler, bound to the top level.
module rrts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rrts_pkg::STAT_W-1:0]   out_status,
  input logic [rrts_pkg::IDX_W-1:0]    out_new_task_id,
  input logic [rrts_pkg::IDX_W-1:0]    out_running_task,
  input logic                          out_idle_running,
  input logic [rrts_pkg::TICK_W-1:0]   out_tick_now
);
  import rrts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_tick_now))
    else $error("result changed while stalled");

  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle_running |-> out_running_task == '0)
    else $error("idle result names a slot");

  a_refused_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_new_task_id == '0)
    else $error("refused request reports a new slot");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not quiet after reset");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (.*);

/* verif/tb.sv */
// Self-checking testbench for the round-robin task scheduler top level.
`timescale 1ns / 100ps

module tb;
  import rrts_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [RATE_W-1:0]    cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type;
  logic [STACK_W-1:0]   in_stack_size_bytes;
  logic [TICK_W-1:0]    in_delay_millis;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    out_status;
  logic [IDX_W-1:0]     out_new_task_id;
  logic [IDX_W-1:0]     out_running_task;
  logic                 out_idle_running;
  logic [TICK_W-1:0]    out_tick_now;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  new_id;
    logic [IDX_W-1:0]  running;
    logic              idle;
    logic [TICK_W-1:0] tick;
  } sched_resp_t;

  // Scheduler shadow state, kept in step with every accepted request.
  logic [RATE_W-1:0] sh_rate;
  logic [SST_W-1:0]  sh_slot_st [MAX_TASKS];
  logic [TICK_W-1:0] sh_wake    [MAX_TASKS];
  int unsigned       sh_used;
  int unsigned       sh_cur;
  bit                sh_idle;
  bit                sh_started;
  logic [TICK_W-1:0] sh_tick;

  sched_resp_t resp_queue[$];
  int unsigned mismatches;
  int unsigned cycles;
  localparam int unsigned CYCLE_LIMIT = 400000;

  round_robin_task_scheduler_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_stack_size_bytes (in_stack_size_bytes),
    .in_delay_millis     (in_delay_millis),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_new_task_id     (out_new_task_id),
    .out_running_task    (out_running_task),
    .out_idle_running    (out_idle_running),
    .out_tick_now        (out_tick_now)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Round-robin pick: from slot 0 on start, else starting after the current slot.
  function automatic int pick_ready(bit from_zero, int unsigned after);
    int unsigned idx;
    if (sh_used == 0) return -1;
    for (int unsigned k = 1; k <= sh_used; k++) begin
      idx = from_zero ? k - 1 : (after + k) % sh_used;
      if (sh_slot_st[idx] == SLOT_READY) return idx;
    end
    return -1;
  endfunction

  function automatic void switch_slot(int idx);
    sh_idle = (idx < 0);
    sh_cur  = (idx < 0) ? 0 : idx;
  endfunction

  function automatic void shadow_reset();
    sh_rate = RATE_RESET;
    for (int i = 0; i < MAX_TASKS; i++) begin
      sh_slot_st[i] = SLOT_READY;
      sh_wake[i] = '0;
    end
    sh_used = 0; sh_cur = 0; sh_idle = 1; sh_started = 0; sh_tick = '0;
  endfunction

  // Apply one request to the shadow state and return the response it produces.
  function automatic sched_resp_t schedule_request(logic [REQ_W-1:0] req,
                                                   logic [STACK_W-1:0] stack,
                                                   logic [TICK_W-1:0] ms);
    sched_resp_t r;
    bit          running;
    logic [63:0] wide;
    logic [TICK_W-1:0] ticks;
    running = sh_started && !sh_idle && sh_cur < sh_used;
    r.status = STAT_OK;
    r.new_id = '0;
    case (req)
      REQ_CREATE: begin
        if (stack < MIN_STACK) r.status = STAT_STACK;
        else if (sh_used >= MAX_TASKS) r.status = STAT_FULL;
        else begin
          r.new_id = IDX_W'(sh_used);
          sh_slot_st[sh_used] = SLOT_READY;
          sh_wake[sh_used] = '0;
          sh_used++;
        end
      end
      REQ_START: begin
        if (sh_started) r.status = STAT_NOT_ALLOW;
        else begin
          sh_started = 1;
          switch_slot(pick_ready(1, 0));
        end
      end
      REQ_TICK: begin
        sh_tick = sh_tick + 1;
        for (int unsigned i = 0; i < sh_used; i++)
          if (sh_slot_st[i] == SLOT_SLEEPING && sh_tick >= sh_wake[i])
            sh_slot_st[i] = SLOT_READY;
      end
      REQ_YIELD: begin
        if (!running) r.status = STAT_NOT_ALLOW;
        else switch_slot(pick_ready(0, sh_cur));
      end
      REQ_DELAY: begin
        if (!running) r.status = STAT_NOT_ALLOW;
        else begin
          wide = {32'd0, ms} * {47'd0, sh_rate};
          ticks = (wide[31:0] + ROUND_UP) / 32'd1000;
          if (ticks == 0) ticks = 1;
          sh_wake[sh_cur] = sh_tick + ticks;
          sh_slot_st[sh_cur] = SLOT_SLEEPING;
          switch_slot(pick_ready(0, sh_cur));
        end
      end
      REQ_EXIT: begin
        if (!running) r.status = STAT_NOT_ALLOW;
        else begin
          sh_slot_st[sh_cur] = SLOT_DONE;
          switch_slot(pick_ready(0, sh_cur));
        end
      end
      default: r.status = STAT_NOT_ALLOW;
    endcase
    r.running = sh_idle ? '0 : IDX_W'(sh_cur);
    r.idle = sh_idle;
    r.tick = sh_tick;
    return r;
  endfunction

  // Send one request: random gap, hold valid until accepted, queue its response.
  // Valid stays high after the accept so a request with no gap follows directly.
  task automatic send_request(logic [REQ_W-1:0] req, logic [STACK_W-1:0] stack,
                              logic [TICK_W-1:0] ms, bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_req_type         <= req;
    in_stack_size_bytes <= stack;
    in_delay_millis     <= ms;
    do @(posedge clk); while (!in_ready);
    resp_queue.push_back(schedule_request(req, stack, ms));
  endtask

  // Drain: drop valid, wait for every response, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (resp_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] rate);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sh_rate = rate;
  endtask

  // Receiver: draw a stall per response, check against the oldest prediction.
  initial begin
    sched_resp_t exp_r;
    sched_resp_t got;
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{out_status, out_new_task_id, out_running_task, out_idle_running,
              out_tick_now};
      if (resp_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
      end else begin
        exp_r = resp_queue.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d id=%0d run=%0d idle=%0d tick=%0d",
                     exp_r.status, exp_r.new_id, exp_r.running, exp_r.idle, exp_r.tick,
                     " got st=%0d id=%0d run=%0d idle=%0d tick=%0d",
                     got.status, got.new_id, got.running, got.idle, got.tick);
        end
      end
    end
  end

  // Watchdog on total cycles.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Pre-start calls, bad codes, create checks, table full, double start, task calls.
  task automatic test_directed();
    send_request(REQ_YIELD, 16'd0, 32'd0);
    send_request(REQ_DELAY, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_EXIT, 16'd0, 32'd0);
    send_request(REQ_TICK, 16'd0, 32'd0);
    send_request(3'd6, 16'd0, 32'd0);
    send_request(3'd7, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_CREATE, 16'd63, 32'd0);
    send_request(REQ_CREATE, 16'd0, 32'd0);
    for (int i = 0; i < MAX_TASKS; i++)
      send_request(REQ_CREATE, (i == 0) ? 16'd64 : 16'hFFFF, 32'd0, i[0]);
    send_request(REQ_CREATE, 16'd100, 32'd0);
    send_request(REQ_CREATE, 16'd10, 32'd0);
    send_request(REQ_START, 16'd0, 32'd0);
    send_request(REQ_START, 16'd0, 32'd0);
    send_request(REQ_DELAY, 16'd0, 32'd0);
    send_request(REQ_DELAY, 16'd0, 32'hFFFF_FFFF);
    send_request(REQ_YIELD, 16'd0, 32'd0);
    send_request(REQ_EXIT, 16'd0, 32'd0);
    send_request(REQ_TICK, 16'd0, 32'd0);
  endtask

  // Random sessions: reset-free, so a few create/start runs then mostly task traffic.
  task automatic run_session(int unsigned n, int unsigned max_ms);
    logic [REQ_W-1:0] req;
    logic [TICK_W-1:0] ms;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) req = REQ_CREATE;
      else if (pick < 6) req = REQ_START;
      else if (pick < 40) req = REQ_TICK;
      else if (pick < 62) req = REQ_YIELD;
      else if (pick < 85) req = REQ_DELAY;
      else if (pick < 95) req = REQ_EXIT;
      else req = REQ_W'($urandom_range(6, 7));
      ms = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, max_ms);
      send_request(req, ($urandom_range(0, 4) == 0) ? STACK_W'($urandom_range(0, 70))
                                                    : STACK_W'($urandom),
                   ms, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_random();
    write_rate(17'd1);
    run_session(300, 3000);
    write_rate(17'd100000);
    run_session(300, 40);
    write_rate(17'h1FFFF);
    run_session(200, 20);
    write_rate(RATE_W'($urandom_range(1, 100000)));
    run_session(500, 200);
    write_rate(RATE_RESET);
    run_session(500, 20);
  endtask

  initial begin
    shadow_reset();
    mismatches = 0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_req_type <= '0;
    in_stack_size_bytes <= '0;
    in_delay_millis <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/rrts_pkg.sv
design/rrts_ram.sv
design/round_robin_task_scheduler_top.sv
design/rrts_checker.sv
verif/tb.sv
